FILE: rtl/rm320_pkg.sv
// ----------------------------------------------------------------------------
// rm320_pkg
// Shared types, round tables and step functions of the RIPEMD-320 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rm320_pkg;

  localparam int NUM_CV      = 10;
  localparam int Q_DEPTH_DEF = 4;

  // input beat
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } in_t;

  // result beat
  typedef struct packed {
    logic [31:0] digest_word;
    logic [3:0]  word_number;
    logic        last_of_digest;
  } out_t;

  // classified item between front and back
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } q_item_t;

  typedef logic [4:0][31:0]        regs5_t;
  typedef logic [NUM_CV-1:0][31:0] cv_t;

  localparam logic [3:0] SEL_L [80] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13};

  localparam logic [3:0] ROT_L [80] = '{
    4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
    4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
    4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
    4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
    4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
    4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
    4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
    4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
    4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6};

  localparam logic [3:0] SEL_R [80] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11};

  localparam logic [3:0] ROT_R [80] = '{
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
    4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
    4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
    4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
    4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
    4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
    4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
    4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
    4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
    4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11};

  localparam logic [31:0] K_L [5] = '{
    32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e};
  localparam logic [31:0] K_R [5] = '{
    32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h00000000};

  // register slot exchanged between the lines at the end of each round
  localparam logic [2:0] SWAP_SLOT [5] = '{3'd1, 3'd3, 3'd0, 3'd2, 3'd4};

  localparam cv_t INIT_CV = {
    32'h3c2d1e0f, 32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210,
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} << s;
    return d[63:32];
  endfunction

  function automatic logic [31:0] mix(input logic [2:0] k, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z);
    logic [31:0] r;
    unique case (k)
      3'd0: r = x ^ y ^ z;
      3'd1: r = (x & y) | (~x & z);
      3'd2: r = (x | ~y) ^ z;
      3'd3: r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

  // one step of one line
  function automatic regs5_t line_step(input regs5_t v, input logic [2:0] k,
                                       input logic [31:0] w, input logic [31:0] c,
                                       input logic [3:0] s);
    regs5_t      n;
    logic [31:0] t;
    t    = rotl(v[0] + mix(k, v[1], v[2], v[3]) + w + c, {1'b0, s}) + v[4];
    n[0] = v[4];
    n[4] = v[3];
    n[3] = rotl(v[2], 5'd10);
    n[2] = v[1];
    n[1] = t;
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rm320_front.sv
// ----------------------------------------------------------------------------
// rm320_front
// Input side: clamps the byte count, drops empty non-final words and queues
// the rest for the compression back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rm320_front #(
  parameter int Q_DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire rm320_pkg::in_t   in_data,
  output logic                  q_valid,
  input  wire logic             q_pop,
  output rm320_pkg::q_item_t    q_item
);
  import rm320_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  q_item_t         fifo_r [Q_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  q_item_t         cls;
  logic            acc, keep, wr, rd;

  // classify the beat
  always_comb begin
    cls.word   = in_data.data_word;
    cls.nbytes = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
    cls.last   = in_data.last_word;
  end

  assign full    = (cnt_r == CW'(Q_DEPTH));
  assign acc     = push && !full;
  assign keep    = cls.last || (cls.nbytes != 3'd0);
  assign wr      = acc && keep;
  assign q_valid = (cnt_r != '0);
  assign rd      = q_pop && q_valid;
  assign q_item  = fifo_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = wr ? ((wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = rd ? ((rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CW'(wr) - CW'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      fifo_r[wp_r] <= cls;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rm320_back.sv
// ----------------------------------------------------------------------------
// rm320_back
// Back end: packs bytes into the block memory, pads, runs both lines one
// step per cycle and hands the digest to a ten-word output bank.
// ----------------------------------------------------------------------------
`default_nettype none

module rm320_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire rm320_pkg::q_item_t q_item,
  output logic                    empty,
  input  wire logic               pop,
  output rm320_pkg::out_t         out_data
);
  import rm320_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD0 = 3'd1;
  localparam logic [2:0] S_PADZ = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_CLD  = 3'd4;
  localparam logic [2:0] S_CRUN = 3'd5;
  localparam logic [2:0] S_CADD = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]  state_r, state_nxt, ret_r, ret_nxt;
  cv_t         cv_r, cv_nxt;
  logic [60:0] msg_r, msg_nxt;
  logic [3:0]  widx_r, widx_nxt;
  logic [1:0]  off_r, off_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [6:0]  j_r, j_nxt;
  regs5_t      lv_r, lv_nxt, rv_r, rv_nxt;
  logic [31:0] mem [16];
  logic [31:0] rd_l_r, rd_r_r;
  logic [6:0]  ridx;
  logic        mem_we;
  logic [31:0] mem_wd;
  cv_t         dig_r, dig_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [3:0]  ocnt_r, ocnt_nxt;

  logic [31:0] ab_word, mw;
  logic [2:0]  ab_n, tot;
  logic [63:0] cat, len;
  logic [2:0]  rnd;
  regs5_t      sl, sr;
  logic [31:0] tsw;

  // byte merge of the current beat (or the pad byte) into the partial word
  always_comb begin
    ab_word = (state_r == S_PAD0) ? 32'h0000_0080 : q_item.word;
    ab_n    = (state_r == S_PAD0) ? 3'd1 : q_item.nbytes;
    for (int b = 0; b < 4; b++) begin
      mw[8*b +: 8] = (3'(b) < ab_n) ? ab_word[8*b +: 8] : 8'h00;
    end
    cat = (64'(mw) << {off_r, 3'b000}) | 64'(acc_r);
    tot = 3'(off_r) + ab_n;
    len = {msg_r, 3'b000};
  end

  // both line steps, with the slot exchange closing each round
  always_comb begin
    rnd = j_r[6:4];
    sl  = line_step(lv_r, rnd, rd_l_r, K_L[rnd], ROT_L[j_r]);
    sr  = line_step(rv_r, 3'd4 - rnd, rd_r_r, K_R[rnd], ROT_R[j_r]);
    tsw = sl[SWAP_SLOT[rnd]];
    if (j_r[3:0] == 4'hf) begin
      sl[SWAP_SLOT[rnd]] = sr[SWAP_SLOT[rnd]];
      sr[SWAP_SLOT[rnd]] = tsw;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cv_nxt    = cv_r;
    msg_nxt   = msg_r;
    widx_nxt  = widx_r;
    off_nxt   = off_r;
    acc_nxt   = acc_r;
    j_nxt     = j_r;
    lv_nxt    = lv_r;
    rv_nxt    = rv_r;
    mem_we    = 1'b0;
    mem_wd    = acc_r;
    q_pop     = 1'b0;
    dig_nxt   = dig_r;
    ovalid_nxt = ovalid_r;
    ocnt_nxt  = ocnt_r;

    unique case (state_r)
      S_IDLE, S_PAD0: begin
        if (state_r == S_PAD0 || q_valid) begin
          if (state_r == S_IDLE) begin
            q_pop   = 1'b1;
            msg_nxt = msg_r + 61'(q_item.nbytes);
          end
          if (tot >= 3'd4) begin
            mem_we   = 1'b1;
            mem_wd   = cat[31:0];
            acc_nxt  = cat[63:32];
            off_nxt  = 2'(tot - 3'd4);
            widx_nxt = widx_r + 4'd1;
          end else begin
            acc_nxt = cat[31:0];
            off_nxt = tot[1:0];
          end
          if (state_r == S_PAD0) begin
            ret_nxt   = S_PADZ;
            state_nxt = S_PADZ;
          end else begin
            ret_nxt   = q_item.last ? S_PAD0 : S_IDLE;
            state_nxt = q_item.last ? S_PAD0 : S_IDLE;
          end
          if (tot >= 3'd4 && widx_r == 4'hf) begin
            state_nxt = S_CLD;
          end
        end
      end
      S_PADZ: begin
        mem_we = 1'b1;
        if (widx_r == 4'd14 && off_r == 2'd0) begin
          mem_wd    = len[31:0];
          widx_nxt  = 4'hf;
          state_nxt = S_LEN;
        end else begin
          mem_wd   = acc_r;
          acc_nxt  = '0;
          off_nxt  = '0;
          widx_nxt = widx_r + 4'd1;
          if (widx_r == 4'hf) begin
            ret_nxt   = S_PADZ;
            state_nxt = S_CLD;
          end
        end
      end
      S_LEN: begin
        mem_we    = 1'b1;
        mem_wd    = len[63:32];
        widx_nxt  = 4'd0;
        ret_nxt   = S_DONE;
        state_nxt = S_CLD;
      end
      S_CLD: begin
        lv_nxt    = cv_r[4:0];
        rv_nxt    = cv_r[9:5];
        j_nxt     = '0;
        state_nxt = S_CRUN;
      end
      S_CRUN: begin
        lv_nxt = sl;
        rv_nxt = sr;
        if (j_r == 7'd79) begin
          state_nxt = S_CADD;
        end else begin
          j_nxt = j_r + 7'd1;
        end
      end
      S_CADD: begin
        for (int i = 0; i < 5; i++) begin
          cv_nxt[i]     = cv_r[i] + lv_r[i];
          cv_nxt[i + 5] = cv_r[i + 5] + rv_r[i];
        end
        state_nxt = ret_r;
      end
      S_DONE: begin
        if (!ovalid_r) begin
          dig_nxt    = cv_r;
          ovalid_nxt = 1'b1;
          ocnt_nxt   = '0;
          cv_nxt     = INIT_CV;
          msg_nxt    = '0;
          widx_nxt   = '0;
          off_nxt    = '0;
          acc_nxt    = '0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // output bank shifts one word per beat
    if (pop && ovalid_r) begin
      dig_nxt  = {32'h0, dig_r[NUM_CV-1:1]};
      ocnt_nxt = ocnt_r + 4'd1;
      if (ocnt_r == 4'(NUM_CV - 1)) begin
        ovalid_nxt = 1'b0;
      end
    end
  end

  // read index one step ahead of the step in use
  assign ridx = (state_r == S_CRUN && j_r != 7'd79) ? j_r + 7'd1 : 7'd0;

  assign empty                   = !ovalid_r;
  assign out_data.digest_word    = dig_r[0];
  assign out_data.word_number    = ocnt_r;
  assign out_data.last_of_digest = (ocnt_r == 4'(NUM_CV - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      cv_r     <= INIT_CV;
      msg_r    <= '0;
      widx_r   <= '0;
      off_r    <= '0;
      acc_r    <= '0;
      j_r      <= '0;
      ovalid_r <= 1'b0;
      ocnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      cv_r     <= cv_nxt;
      msg_r    <= msg_nxt;
      widx_r   <= widx_nxt;
      off_r    <= off_nxt;
      acc_r    <= acc_nxt;
      j_r      <= j_nxt;
      ovalid_r <= ovalid_nxt;
      ocnt_r   <= ocnt_nxt;
    end
  end

  // working registers and digest bank
  always_ff @(posedge clk) begin
    lv_r  <= lv_nxt;
    rv_r  <= rv_nxt;
    dig_r <= dig_nxt;
  end

  // block memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[widx_r] <= mem_wd;
    end
    rd_l_r <= mem[SEL_L[ridx]];
    rd_r_r <= mem[SEL_R[ridx]];
  end

endmodule

`default_nettype wire

FILE: rtl/ripemd320_hash_engine_top.sv
// ----------------------------------------------------------------------------
// ripemd320_hash_engine_top
// RIPEMD-320 hash engine: word stream in, ten-word digest out.
// ----------------------------------------------------------------------------
// Push message words, first byte in bits 7:0; byte_count above four counts as
// four and only the final word (last_word set) should be short. The back end
// takes beats one at a time from the input queue; every 64th byte starts a
// compression (load, 80 steps of both lines from the two-read block memory,
// chaining add), during which no beats are taken. The last word adds padding
// and one or two compressions, then the ten digest words appear in order on
// the result queue. The input queue of Q_DEPTH entries lets words be pushed
// while a compression is running.
// ----------------------------------------------------------------------------
`default_nettype none

module ripemd320_hash_engine_top #(
  parameter int Q_DEPTH = rm320_pkg::Q_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire rm320_pkg::in_t  in_data,
  output logic                 empty,
  input  wire logic            pop,
  output rm320_pkg::out_t      out_data
);
  import rm320_pkg::*;

  logic    q_valid, q_pop;
  q_item_t q_item;

  rm320_front #(.Q_DEPTH(Q_DEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  rm320_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/rm320_checker.sv
// ----------------------------------------------------------------------------
// rm320_checker
// Port-level checks of the digest sequence, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rm320_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            empty,
  input wire logic            pop,
  input wire rm320_pkg::out_t out_data
);

  // nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // digest words come in order without gaps
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_data.last_of_digest) |=>
      (!empty && out_data.word_number == $past(out_data.word_number) + 4'd1))
    else $error("digest word out of order");

  // final flag marks word nine only
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.last_of_digest == (out_data.word_number == 4'd9)))
    else $error("last_of_digest mismatch");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result changed while stalled");

endmodule

bind ripemd320_hash_engine_top rm320_checker u_chk (.*);

`default_nettype wire

FILE: sim/tb_ripemd320_hash_engine_top.sv
// ----------------------------------------------------------------------------
// tb_ripemd320_hash_engine_top
// Self-checking bench for the RIPEMD-320 engine: messages of random length
// are pushed as word beats, a local digest model predicts the ten digest
// words per message and every popped beat is compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ripemd320_hash_engine_top;
  import rm320_pkg::*;

  // round tables of the hash
  localparam int TS_L [80] = '{
    0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
    7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
    3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
    1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
    4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
  localparam int TR_L [80] = '{
    11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
    7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
    11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
    11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
    9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
  localparam int TS_R [80] = '{
    5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
    6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
    15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
    8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
    12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
  localparam int TR_R [80] = '{
    8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
    9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
    9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
    15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
    8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
  localparam logic [31:0] KC_L [5] = '{
    32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e};
  localparam logic [31:0] KC_R [5] = '{
    32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h00000000};
  localparam int XCHG [5] = '{1, 3, 0, 2, 4};
  localparam logic [31:0] IV [10] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0,
    32'h76543210, 32'hfedcba98, 32'h89abcdef, 32'h01234567, 32'h3c2d1e0f};
  localparam int  N_ITEMS   = 420;
  localparam longint LIMIT  = 2000000;

  logic clk, rst_n, push, full, empty, pop;
  in_t  in_data;
  out_t out_data;

  ripemd320_hash_engine_top uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data));

  // digest model state
  logic [31:0] hv [10];
  logic [31:0] blk [16];
  logic [60:0] msg_len;
  int          fill;

  in_t  word_q [$];
  out_t digest_q [$];
  int   errors = 0;
  int   n_digests = 0;
  int   n_beats = 0;
  longint cycle;
  bit   hold_drain;

  function automatic logic [31:0] rol(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] fmix(int k, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z);
    case (k)
      0: return x ^ y ^ z;
      1: return (x & y) | (~x & z);
      2: return (x | ~y) ^ z;
      3: return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  task automatic round_step(ref logic [31:0] v [5], input int k, input logic [31:0] w,
                            input logic [31:0] c, input int s);
    logic [31:0] t;
    t = rol(v[0] + fmix(k, v[1], v[2], v[3]) + w + c, s) + v[4];
    v[0] = v[4];
    v[4] = v[3];
    v[3] = rol(v[2], 10);
    v[2] = v[1];
    v[1] = t;
  endtask

  task automatic compress_block();
    logic [31:0] lv [5];
    logic [31:0] rv [5];
    logic [31:0] t;
    for (int i = 0; i < 5; i++) begin
      lv[i] = hv[i];
      rv[i] = hv[i + 5];
    end
    for (int r = 0; r < 5; r++) begin
      for (int i = r * 16; i < r * 16 + 16; i++) begin
        round_step(lv, r, blk[TS_L[i]], KC_L[r], TR_L[i]);
        round_step(rv, 4 - r, blk[TS_R[i]], KC_R[r], TR_R[i]);
      end
      t = lv[XCHG[r]];
      lv[XCHG[r]] = rv[XCHG[r]];
      rv[XCHG[r]] = t;
    end
    for (int i = 0; i < 5; i++) begin
      hv[i] += lv[i];
      hv[i + 5] += rv[i];
    end
  endtask

  task automatic absorb_byte(logic [7:0] b);
    blk[fill >> 2][(fill & 3) * 8 +: 8] = b;
    fill = (fill + 1) & 63;
    if (fill == 0) compress_block();
  endtask

  task automatic restart_digest();
    for (int i = 0; i < 10; i++) hv[i] = IV[i];
    msg_len = '0;
    fill = 0;
  endtask

  // predict the digest beats caused by one accepted word
  task automatic predict_digest(in_t w);
    int n;
    logic [63:0] bits;
    out_t o;
    n = (w.byte_count > 4) ? 4 : w.byte_count;
    for (int i = 0; i < n; i++) begin
      absorb_byte(w.data_word[8 * i +: 8]);
      msg_len++;
    end
    if (!w.last_word) return;
    bits = {msg_len, 3'b000};
    absorb_byte(8'h80);
    while (fill != 56) absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) absorb_byte(bits[8 * i +: 8]);
    for (int i = 0; i < 10; i++) begin
      o.digest_word = hv[i];
      o.word_number = 4'(i);
      o.last_of_digest = (i == 9);
      digest_q.push_back(o);
    end
    restart_digest();
  endtask

  task automatic report(string what, out_t got, out_t want);
    errors++;
    $display("MISMATCH %s: got %h/%0d/%0d want %h/%0d/%0d", what, got.digest_word,
             got.word_number, got.last_of_digest, want.digest_word,
             want.word_number, want.last_of_digest);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic in_t mk_word(logic [31:0] d, int n, bit l);
    in_t w;
    w.data_word = d;
    w.byte_count = 3'(n);
    w.last_word = l;
    return w;
  endfunction

  // queue a message of nb full-word beats with a last word of tail bytes
  task automatic queue_message(int nb, int tail_n);
    for (int i = 0; i < nb; i++) word_q.push_back(mk_word($urandom(), 4, 0));
    word_q.push_back(mk_word($urandom(), tail_n, 1));
  endtask

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // stimulus
  initial begin
    int k, r;
    // directed: empty message, byte counts 0..7, extreme data
    word_q.push_back(mk_word(32'hffffffff, 0, 1));
    word_q.push_back(mk_word(32'h00000000, 4, 1));
    word_q.push_back(mk_word(32'hffffffff, 4, 1));
    word_q.push_back(mk_word(32'h12345678, 1, 0));
    word_q.push_back(mk_word(32'hdeadbeef, 0, 0));
    word_q.push_back(mk_word(32'hcafef00d, 3, 0));
    word_q.push_back(mk_word(32'ha5a5a5a5, 7, 0));
    word_q.push_back(mk_word(32'h5a5a5a5a, 5, 0));
    word_q.push_back(mk_word(32'h0f0f0f0f, 6, 1));
    word_q.push_back(mk_word(32'h00616263, 3, 1));
    word_q.push_back(mk_word(32'h00000061, 2, 1));
    queue_message(13, 3);   // pad fits in one block
    queue_message(13, 4);   // pad spills into a second block
    k = word_q.size();
    // random: mostly well-formed messages, some with short or odd middle words
    while (k < N_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) queue_message($urandom_range(0, 20), $urandom_range(0, 4));
      else if (r < 85) queue_message($urandom_range(20, 40), $urandom_range(0, 7));
      else begin
        repeat ($urandom_range(1, 6))
          word_q.push_back(mk_word($urandom(), $urandom_range(0, 7), 0));
        word_q.push_back(mk_word($urandom(), $urandom_range(0, 7), 1));
      end
      k = word_q.size();
    end
  end

  // driver: push beats from word_q with random gaps
  int gap;
  int sent;
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 0;
      in_data <= '0;
      gap <= 0;
      sent <= 0;
      hold_drain <= 0;
      restart_digest();
      for (int i = 0; i < 16; i++) blk[i] = '0;
    end else begin
      if (push && !full) begin
        predict_digest(in_data);
        sent <= sent + 1;
      end
      if (push && full) begin
        // hold beat
      end else if (gap > 0) begin
        push <= 0;
        gap <= gap - 1;
      end else if (sent >= 150 && !hold_drain) begin
        // pause once until every expected digest beat has been popped
        push <= 0;
        if (digest_q.size() == 0) hold_drain <= 1;
      end else if (word_q.size() != 0) begin
        push <= 1;
        in_data <= word_q.pop_front();
        gap <= gap_len();
      end else begin
        push <= 0;
      end
    end
  end

  // monitor: random pop gaps, check against oldest expected digest beat
  int pgap;
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      pop <= 0;
      pgap <= 0;
    end else begin
      if (pop && !empty) begin
        n_beats++;
        if (digest_q.size() == 0) begin
          report("unexpected beat", out_data, '0);
        end else begin
          want = digest_q.pop_front();
          if (out_data.digest_word != want.digest_word)
            report("digest_word", out_data, want);
          if (out_data.word_number != want.word_number)
            report("word_number", out_data, want);
          if (out_data.last_of_digest != want.last_of_digest)
            report("last_of_digest", out_data, want);
          if (want.last_of_digest) n_digests++;
        end
      end
      if (pgap > 0) begin
        pop <= 0;
        pgap <= pgap - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        pop <= 0;
        pgap <= gap_len();
      end else begin
        pop <= 1;
      end
    end
  end

  // reset, end of run and limit
  initial begin
    cycle = 0;
    rst_n = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    while ((word_q.size() != 0 || push || digest_q.size() != 0) && cycle < LIMIT) begin
      @(posedge clk);
      cycle++;
    end
    if (cycle >= LIMIT) begin
      $display("Timeout after %0d cycles", cycle);
      $display("Some tests failed");
    end else begin
      repeat (400) @(posedge clk);
      $display("Covered %0d input words, %0d digests (%0d beats) with random gaps",
               sent, n_digests, n_beats);
      if (errors == 0 && digest_q.size() == 0)
        $display("All tests passed");
      else
        $display("Some tests failed");
    end
    $finish;
  end

endmodule
